### rtl/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared constants and stage payload types for the binary16 multiplier.
// ----------------------------------------------------------------------------
package hpm_pkg;

  localparam logic [15:0] HALF_QUIET_BIT   = 16'h0200;
  localparam logic [14:0] HALF_INF_BITS    = 15'h7C00;
  localparam logic [15:0] HALF_DEFAULT_NAN = 16'hFE00;

  // Operands split and classified; special results decided early.
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [15:0] special_word;
    logic [10:0] sig_a;
    logic [10:0] sig_b;
    logic signed [7:0] pw;
  } hpm_s1_t;

  // Exact product with its exponent.
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [15:0] special_word;
    logic [21:0] prod;
    logic signed [7:0] pw;
  } hpm_s2_t;

  // Aligned: a right shift of prod by shift leaves the target significand
  // in its low bits, with the dropped bits below it.
  typedef struct packed {
    logic        sign;
    logic        special;
    logic [15:0] special_word;
    logic [21:0] prod;
    logic [4:0]  shift;
    logic signed [7:0] k;
  } hpm_s3_t;

endpackage

### rtl/hpm_round.sv
// ----------------------------------------------------------------------------
// hpm_round
// Right shift of the normalized product, round to nearest even, and packing.
// ----------------------------------------------------------------------------
module hpm_round import hpm_pkg::*; (
  input  hpm_s3_t     s3,
  output logic [15:0] word
);

  logic [32:0] wide;
  logic [11:0] q;
  logic        half_bit;
  logic        sticky;
  logic [11:0] qr;
  logic signed [8:0] kf;
  logic [14:0] mag;

  always_comb begin
    // The product sits above 22 guard bits; after the shift the kept
    // significand is in bits 32:22, the first dropped bit is bit 21 and
    // everything below it folds into sticky.
    wide     = 33'({s3.prod, 22'd0} >> s3.shift);
    q        = {1'b0, wide[32:22]};
    half_bit = wide[21];
    sticky   = |wide[20:0];
    qr       = q + 12'(half_bit && (sticky || q[0]));
    kf       = 9'(s3.k);
    if (qr[11]) begin
      qr = qr >> 1;
      kf = kf + 9'sd1;
    end
    if (qr == 12'd0) begin
      mag = 15'd0;
    end else if (!qr[10]) begin
      mag = {5'd0, qr[9:0]};
    end else if (kf + 9'sd25 >= 9'sd31) begin
      mag = HALF_INF_BITS;
    end else begin
      mag = {5'(kf + 9'sd25), qr[9:0]};
    end
    word = s3.special ? s3.special_word : {s3.sign, mag};
  end

endmodule

### rtl/half_precision_multiplier_top.sv
// ----------------------------------------------------------------------------
// half_precision_multiplier_top
// Pipelined IEEE binary16 multiplier with round to nearest even.
// ----------------------------------------------------------------------------
// done rises together with product_half: each word passes the s1, s2 and s3
// registers and then product_half, while valid shifts alongside it.
// Throughput: one word per cycle; busy is always low since the receiver
// cannot stall and every stage advances each cycle.
// Reset clears the stage valid bits only; payload registers are not reset.
// Stages: classify and split, 11x11 multiply, leading-one normalize, round.
module half_precision_multiplier_top import hpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] multiplicand,
  input  logic [15:0] multiplier,
  output logic        done,
  output logic [15:0] product_half
);

  hpm_s1_t s1, s1_next;
  hpm_s2_t s2;
  hpm_s3_t s3, s3_next;
  logic [3:0] valid;
  logic [15:0] word;

  assign busy = 1'b0;

  // Stage 1: classify both operands and split off significands.
  always_comb begin
    logic [4:0] ea, eb;
    logic [9:0] fa, fb;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    ea = multiplicand[14:10]; eb = multiplier[14:10];
    fa = multiplicand[9:0];   fb = multiplier[9:0];
    a_nan  = (ea == 5'h1F) && (fa != 10'd0);
    b_nan  = (eb == 5'h1F) && (fb != 10'd0);
    a_inf  = (ea == 5'h1F) && (fa == 10'd0);
    b_inf  = (eb == 5'h1F) && (fb == 10'd0);
    a_zero = multiplicand[14:0] == 15'd0;
    b_zero = multiplier[14:0] == 15'd0;
    sgn    = multiplicand[15] ^ multiplier[15];
    s1_next.sign    = sgn;
    s1_next.special = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
    if (a_nan)
      s1_next.special_word = multiplicand | HALF_QUIET_BIT;
    else if (b_nan)
      s1_next.special_word = multiplier | HALF_QUIET_BIT;
    else if ((a_inf || b_inf) && (a_zero || b_zero))
      s1_next.special_word = HALF_DEFAULT_NAN;
    else if (a_inf || b_inf)
      s1_next.special_word = {sgn, HALF_INF_BITS};
    else
      s1_next.special_word = {sgn, 15'd0};
    s1_next.sig_a = {ea != 5'd0, fa};
    s1_next.sig_b = {eb != 5'd0, fb};
    // Subnormals use a biased exponent of one.
    s1_next.pw = 8'(signed'({3'd0, (ea == 5'd0) ? 5'd1 : ea}))
               + 8'(signed'({3'd0, (eb == 5'd0) ? 5'd1 : eb})) - 8'sd50;
  end

  // Stage 3: find the leading one of the product and derive the target
  // exponent k, clamped at the subnormal floor.
  always_comb begin
    logic [4:0] m;
    logic signed [7:0] k, sh;
    m = 5'd0;
    for (int i = 0; i < 22; i++) begin
      if (s2.prod[i]) m = 5'(i);
    end
    k = 8'(signed'({3'd0, m})) + s2.pw - 8'sd10;
    if (k < -8'sd24) k = -8'sd24;
    sh = k - s2.pw;
    s3_next.sign         = s2.sign;
    s3_next.special      = s2.special;
    s3_next.special_word = s2.special_word;
    s3_next.k            = k;
    // A left shift is exact and needs no rounding; a right shift is left to
    // the rounder. Shifts past the product send everything below half an ulp.
    if (sh <= 8'sd0) begin
      s3_next.prod  = s2.prod << 5'(-sh);
      s3_next.shift = 5'd0;
    end else if (sh > 8'sd23) begin
      s3_next.prod  = s2.prod;
      s3_next.shift = 5'd31;
    end else begin
      s3_next.prod  = s2.prod;
      s3_next.shift = 5'(sh);
    end
  end

  hpm_round u_round (
    .s3   (s3),
    .word (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 4'd0;
    end else begin
      valid <= {valid[2:0], start};
    end
    s1 <= s1_next;
    s2.sign         <= s1.sign;
    s2.special      <= s1.special;
    s2.special_word <= s1.special_word;
    s2.prod         <= {11'd0, s1.sig_a} * {11'd0, s1.sig_b};
    s2.pw           <= s1.pw;
    s3 <= s3_next;
    product_half <= word;
  end

  assign done = valid[3];

endmodule

### sim/tb_half_precision_multiplier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_half_precision_multiplier_top
// Self-checking bench for the pipelined binary16 multiplier. A directed
// table covers zeros, infinities, NaNs, subnormals, rounding and overflow.
// Random operand pairs follow, sent in bursts with random gaps between them.
// Every product is compared with a behavioral model of the multiply.
// ----------------------------------------------------------------------------
module tb_half_precision_multiplier_top;
  import hpm_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned RANDOM_WORDS = 1330;
  localparam int unsigned STALL_LIMIT  = 2000;

  // One row of the directed table. When has_gold is set, the gold column
  // is also compared with the model, so the table checks the model as well.
  typedef struct {
    logic [15:0] lhs;
    logic [15:0] rhs;
    bit          has_gold;
    logic [15:0] gold;
  } mul_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] multiplicand;
  logic [15:0] multiplier;
  logic        done;
  logic [15:0] product_half;

  logic [15:0] product_queue[$];
  int unsigned error_count;
  int unsigned products_checked;
  int unsigned idle_cycles;

  half_precision_multiplier_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .multiplicand(multiplicand),
    .multiplier  (multiplier),
    .done        (done),
    .product_half(product_half)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Prints one line for each mismatch and counts it.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Behavioral binary16 product, rounded to nearest even. The value is
  // formed as an exact integer product times a power of two and rounded once.
  function automatic logic [15:0] half_product(input logic [15:0] a,
                                               input logic [15:0] b);
    logic        sgn;
    logic [4:0]  ea;
    logic [4:0]  eb;
    logic [9:0]  fa;
    logic [9:0]  fb;
    logic [31:0] sig_a;
    logic [31:0] sig_b;
    logic [31:0] prod;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half_ulp;
    int          scale;
    int          msb;
    int          k;
    int          sh;
    sgn = a[15] ^ b[15];
    ea = a[14:10];
    eb = b[14:10];
    fa = a[9:0];
    fb = b[9:0];
    // A NaN on the left wins; the result is that NaN made quiet.
    if (ea == 5'h1F && fa != 0) return a | HALF_QUIET_BIT;
    if (eb == 5'h1F && fb != 0) return b | HALF_QUIET_BIT;
    if (ea == 5'h1F || eb == 5'h1F) begin
      if (a[14:0] == 0 || b[14:0] == 0) return HALF_DEFAULT_NAN;
      return {sgn, HALF_INF_BITS};
    end
    if (a[14:0] == 0 || b[14:0] == 0) return {sgn, 15'd0};
    sig_a = (ea == 0) ? {22'd0, fa} : {21'd0, 1'b1, fa};
    sig_b = (eb == 0) ? {22'd0, fb} : {21'd0, 1'b1, fb};
    scale = ((ea == 0) ? -24 : int'(ea) - 25) + ((eb == 0) ? -24 : int'(eb) - 25);
    prod = sig_a * sig_b;
    msb = 0;
    for (int i = 0; i < 32; i++) if (prod[i]) msb = i;
    // Target form is q * 2^k with q holding 11 bits, or k pinned at the
    // subnormal exponent.
    k = msb + scale - 10;
    if (k < -24) k = -24;
    sh = k - scale;
    if (sh <= 0) begin
      q = prod << (-sh);
    end else if (sh >= 32) begin
      q = 0;
    end else begin
      half_ulp = 32'd1 << (sh - 1);
      rem = prod & ((32'd1 << sh) - 1);
      q = prod >> sh;
      if (rem > half_ulp || (rem == half_ulp && q[0])) q++;
    end
    if (q >= 2048) begin
      q = q >> 1;
      k++;
    end
    if (q == 0) return {sgn, 15'd0};
    if (q < 1024) return {sgn, q[14:0]};
    if (k + 25 >= 31) return {sgn, HALF_INF_BITS};
    return {sgn, 5'(k + 25), q[9:0]};
  endfunction

  // Presents one word and holds it until an edge with busy low takes it.
  task automatic send_word(input logic [15:0] a, input logic [15:0] b);
    start        <= 1'b1;
    multiplicand <= a;
    multiplier   <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    product_queue.push_back(half_product(a, b));
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Draws an operand, leaning on the edges of the exponent range so that
  // subnormals, overflow and the special encodings come up often.
  function automatic logic [15:0] pick_operand();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: w[14:10] = 5'd0;
      1: w[14:10] = 5'd31;
      2: w[14:10] = 5'($urandom_range(1, 4));
      3: w[14:10] = 5'($urandom_range(26, 30));
      4: w[14:0] = 15'd0;
      default: ;
    endcase
    return w;
  endfunction

  // Result checker: the receiver cannot stall, so every done strobe is a
  // word that must match the oldest product still owed.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (product_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected product %h", product_half));
      end else begin
        logic [15:0] want;
        want = product_queue.pop_front();
        products_checked++;
        if (product_half !== want)
          report_mismatch($sformatf("product_half got %h want %h", product_half, want));
      end
    end
  end

  // Watchdog: counts cycles in which no word is accepted either way.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d products owed", product_queue.size());
        $display("half_precision_multiplier_top regression: fail");
        $finish;
      end
    end
  end

  mul_row_t directed_rows[] = '{
    '{16'h0000, 16'h0000, 1'b1, 16'h0000},   // positive zeros
    '{16'h8000, 16'h3C00, 1'b1, 16'h8000},   // negative zero keeps the XOR sign
    '{16'h3C00, 16'h3C00, 1'b1, 16'h3C00},   // one times one
    '{16'h7C00, 16'h0000, 1'b1, 16'hFE00},   // infinity times zero
    '{16'h8000, 16'hFC00, 1'b1, 16'hFE00},   // zero times negative infinity
    '{16'h7C00, 16'hC000, 1'b1, 16'hFC00},   // infinity times a finite value
    '{16'h7C01, 16'h7E55, 1'b1, 16'h7E01},   // left NaN wins and goes quiet
    '{16'h3C00, 16'hFD23, 1'b1, 16'hFF23},   // right NaN made quiet
    '{16'hFFFF, 16'h0000, 1'b1, 16'hFFFF},   // all-ones NaN on the left
    '{16'h7BFF, 16'h7BFF, 1'b1, 16'h7C00},   // overflow to infinity
    '{16'h7BFF, 16'hBC00, 1'b1, 16'hFBFF},   // largest finite kept
    '{16'h0001, 16'h0001, 1'b1, 16'h0000},   // underflow to zero
    '{16'h0001, 16'h3C00, 1'b1, 16'h0001},   // smallest subnormal kept
    '{16'h0001, 16'h3800, 1'b1, 16'h0000},   // tie at half the smallest, to even
    '{16'h0003, 16'h3800, 1'b1, 16'h0002},   // tie rounds up to even
    '{16'h03FF, 16'h4000, 1'b1, 16'h07FE},   // subnormal grows into normal range
    '{16'h0400, 16'h3800, 1'b1, 16'h0200},   // normal falls to subnormal
    '{16'h3C01, 16'h3C01, 1'b0, 16'h0000},   // rounding just above one
    '{16'h3BFF, 16'h3C01, 1'b0, 16'h0000},
    '{16'h5BFF, 16'h5BFF, 1'b0, 16'h0000},   // near the top of the range
    '{16'h1400, 16'h1400, 1'b0, 16'h0000},   // deep underflow path
    '{16'hAAAA, 16'h5555, 1'b0, 16'h0000},
    '{16'h5555, 16'hAAAA, 1'b0, 16'h0000}
  };

  initial begin
    int unsigned sent;
    int unsigned burst;
    error_count      = 0;
    products_checked = 0;
    idle_cycles      = 0;
    start        = 1'b0;
    multiplicand = 16'd0;
    multiplier   = 16'd0;
    rst          = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed rows go back to back, with no gaps between them.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_gold &&
          half_product(directed_rows[i].lhs, directed_rows[i].rhs) !== directed_rows[i].gold)
        report_mismatch($sformatf("table row %0d: model disagrees with gold %h",
                                  i, directed_rows[i].gold));
      send_word(directed_rows[i].lhs, directed_rows[i].rhs);
    end
    go_idle();

    // Drain fully once before the random part starts.
    while (product_queue.size() != 0) @(posedge clk);

    // Random bursts with random gaps; some bursts run long with no gaps.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < RANDOM_WORDS; j++) begin
        send_word(pick_operand(), pick_operand());
        sent++;
      end
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if (sent == RANDOM_WORDS / 2)
        while (product_queue.size() != 0) @(posedge clk);
    end

    while (product_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Covered %0d directed and %0d random operand pairs; %0d products checked.",
             directed_rows.size(), RANDOM_WORDS, products_checked);
    $display("Special encodings, subnormals, rounding ties and overflow were exercised.");
    if (error_count == 0) begin
      $display("half_precision_multiplier_top regression: pass");
    end else begin
      $display("half_precision_multiplier_top regression: fail");
    end
    $finish;
  end
endmodule

### files.f
rtl/hpm_pkg.sv
rtl/hpm_round.sv
rtl/half_precision_multiplier_top.sv
sim/tb_half_precision_multiplier_top.sv
